// ----- hw/rtl/pbmdec_pkg.sv -----
package pbmdec_pkg;

  localparam int DIM_BITS_DEF = 12;

  localparam int KIND_W  = 3;
  localparam int ADDR_W  = 24;
  localparam int VAL_W   = 8;
  localparam int DIM_W   = 12;
  localparam int COUNT_W = 24;
  localparam int OUT_DATA_W = ADDR_W + VAL_W + DIM_W + DIM_W + COUNT_W;

  localparam logic [KIND_W-1:0] KIND_PIXEL    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NOT_PBM  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SHORT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BAD_DIM  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;

  localparam logic [7:0] CH_P   = 8'h50;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_4   = 8'h34;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [VAL_W-1:0] PIX_BLACK = 8'h00;
  localparam logic [VAL_W-1:0] PIX_WHITE = 8'hFF;

  typedef enum logic [3:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_SKIP_W,
    PH_WIDTH,
    PH_SKIP_H,
    PH_HEIGHT,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic                done;
    logic                emit;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   addr;
    logic [VAL_W-1:0]    val;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

// ----- hw/rtl/pbmdec_parse.sv -----
module pbmdec_parse import pbmdec_pkg::*; #(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [7:0] byte_i,
  input  logic       eod_i,
  output res_t       res
);

  localparam int DB = DIM_BITS;
  localparam logic [DB+3:0] ACC_SAT_W = {3'b000, 1'b1, {DB{1'b0}}};
  localparam logic [DB:0]   ACC_SAT   = {1'b1, {DB{1'b0}}};
  localparam logic [DB-1:0] ONE_D     = {{(DB-1){1'b0}}, 1'b1};

  phase_t              phase_r, phase_nxt;
  logic                packed_r, packed_nxt;
  logic [DB-1:0]       width_r, width_nxt;
  logic [DB-1:0]       height_r, height_nxt;
  logic [DB:0]         acc_r, acc_nxt;
  logic                stop_r, stop_nxt;
  logic [DB-1:0]       col_r, col_nxt;
  logic [ADDR_W-1:0]   row_r, row_nxt;
  logic [COUNT_W-1:0]  seen_r, seen_nxt;
  logic [KIND_W-1:0]   err_r, err_nxt;
  logic [DB-1:0]       rows_r, rows_nxt;
  logic [2:0]          bit_r, bit_nxt;

  logic                is_ws, is_dig, acc_over, black, row_end;
  logic [DB+3:0]       acc_mul;
  logic [DB:0]         acc_fed;
  logic [DB-1:0]       acc_val, hm1, col_inc;
  logic [2*DB-1:0]     prod;
  logic [COUNT_W-1:0]  seen_inc;
  logic [ADDR_W-1:0]   pix_addr;

  always_comb begin
    is_ws    = byte_i == CH_SP || (byte_i >= CH_TAB && byte_i <= CH_CR);
    is_dig   = byte_i >= CH_0 && byte_i <= CH_9;
    acc_over = acc_r[DB];
    acc_val  = acc_r[DB-1:0];
    acc_mul  = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + (DB+4)'(byte_i[3:0]);
    acc_fed  = (acc_mul > ACC_SAT_W) ? ACC_SAT : acc_mul[DB:0];
    hm1      = acc_val - ONE_D;
    prod     = (2*DB)'(width_r) * (2*DB)'(hm1);
    black    = packed_r ? byte_i[~bit_r] : (byte_i == CH_1);
    pix_addr = row_r + ADDR_W'(col_r);
    seen_inc = seen_r + COUNT_W'(1);
    col_inc  = col_r + ONE_D;
    row_end  = col_inc == width_r;
  end

  always_comb begin
    phase_nxt  = phase_r;
    packed_nxt = packed_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    acc_nxt    = acc_r;
    stop_nxt   = stop_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    rows_nxt   = rows_r;
    bit_nxt    = bit_r;

    res        = '0;
    res.done   = 1'b1;
    res.kind   = KIND_NONE;
    res.width  = DIM_W'(width_r);
    res.height = DIM_W'(height_r);
    res.count  = seen_r;

    if (eod_i) begin
      res.emit = 1'b1;
      unique case (phase_r)
        PH_MAGIC0, PH_MAGIC1: res.kind = KIND_NOT_PBM;
        PH_HEIGHT: begin
          if (acc_over) begin
            res.kind = KIND_BAD_DIM;
          end else begin
            res.height = DIM_W'(acc_val);
            res.kind   = (width_r == '0 || acc_val == '0) ? KIND_COMPLETE : KIND_SHORT;
          end
        end
        PH_DONE:  res.kind = KIND_COMPLETE;
        PH_ERROR: res.kind = err_r;
        default:  res.kind = KIND_SHORT;
      endcase
      phase_nxt  = PH_MAGIC0;
      packed_nxt = 1'b0;
      width_nxt  = '0;
      height_nxt = '0;
      acc_nxt    = '0;
      stop_nxt   = 1'b0;
      col_nxt    = '0;
      row_nxt    = '0;
      seen_nxt   = '0;
      err_nxt    = '0;
      rows_nxt   = '0;
      bit_nxt    = '0;
    end else begin
      unique case (phase_r)
        PH_MAGIC0: begin
          if (byte_i != CH_P) begin
            res.emit  = 1'b1;
            res.kind  = KIND_NOT_PBM;
            err_nxt   = KIND_NOT_PBM;
            phase_nxt = PH_ERROR;
          end else begin
            phase_nxt = PH_MAGIC1;
          end
        end
        PH_MAGIC1: begin
          if (byte_i == CH_1 || byte_i == CH_4) begin
            packed_nxt = byte_i == CH_4;
            phase_nxt  = PH_SKIP_W;
          end else begin
            res.emit  = 1'b1;
            res.kind  = KIND_NOT_PBM;
            err_nxt   = KIND_NOT_PBM;
            phase_nxt = PH_ERROR;
          end
        end
        PH_SKIP_W, PH_SKIP_H: begin
          if (!is_ws) begin
            acc_nxt   = is_dig ? (DB+1)'(byte_i[3:0]) : '0;
            stop_nxt  = !is_dig;
            phase_nxt = (phase_r == PH_SKIP_W) ? PH_WIDTH : PH_HEIGHT;
          end
        end
        PH_WIDTH, PH_HEIGHT: begin
          if (is_ws) begin
            if (acc_over) begin
              res.emit  = 1'b1;
              res.kind  = KIND_BAD_DIM;
              err_nxt   = KIND_BAD_DIM;
              phase_nxt = PH_ERROR;
            end else if (phase_r == PH_WIDTH) begin
              width_nxt = acc_val;
              phase_nxt = PH_SKIP_H;
            end else begin
              height_nxt = acc_val;
              if (width_r == '0 || acc_val == '0) begin
                phase_nxt = PH_DONE;
              end else begin
                row_nxt   = ADDR_W'(prod);
                col_nxt   = '0;
                rows_nxt  = acc_val;
                phase_nxt = PH_DATA;
              end
            end
          end else if (!stop_r && is_dig) begin
            acc_nxt = acc_fed;
          end else begin
            stop_nxt = 1'b1;
          end
        end
        PH_DATA: begin
          if (packed_r || byte_i == CH_0 || byte_i == CH_1) begin
            res.emit  = 1'b1;
            res.kind  = KIND_PIXEL;
            res.addr  = pix_addr;
            res.val   = black ? PIX_BLACK : PIX_WHITE;
            res.count = seen_inc;
            seen_nxt  = seen_inc;
            if (row_end) begin
              col_nxt  = '0;
              row_nxt  = row_r - ADDR_W'(width_r);
              rows_nxt = rows_r - ONE_D;
              if (rows_r == ONE_D) begin
                phase_nxt = PH_DONE;
              end
            end else begin
              col_nxt = col_inc;
            end
            if (packed_r) begin
              res.done = row_end || bit_r == 3'd7;
              bit_nxt  = res.done ? 3'd0 : bit_r + 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC0;
      packed_r <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
      acc_r    <= '0;
      stop_r   <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      seen_r   <= '0;
      err_r    <= '0;
      rows_r   <= '0;
      bit_r    <= '0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      packed_r <= packed_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      acc_r    <= acc_nxt;
      stop_r   <= stop_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      seen_r   <= seen_nxt;
      err_r    <= err_nxt;
      rows_r   <= rows_nxt;
      bit_r    <= bit_nxt;
    end
  end

endmodule

// ----- hw/rtl/pbm_image_stream_decoder_top.sv -----
// channel | dir | tdata (low bit up)                                | tuser | tlast
// in_     | in  | data_byte[7:0]                                    | -     | end_of_data
// out_    | out | pixel_address, pixel_value, image_width,          | kind  | last_of_run
//         |     | image_height, pixel_count (80 bits)               |       |
// header bytes and plain P1 raster bytes are taken back to back while out_tready does not stall
// a packed P4 raster byte is held in the input register until it has yielded every pixel, up to 8,
// one at a time through the single pixel unit behind the input register
// an input word reaches its result word through the input register and then the output register
// synchronous active-low reset returns the parser to the first magic byte
// input is taken while a result waits; stalls on out_tready hold the pixel unit
module pbm_image_stream_decoder_top import pbmdec_pkg::*; #(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte
  input  logic                  in_tlast,   // end_of_data
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pixel_address, pixel_value, image_width,
                                            // image_height, pixel_count
  output logic [KIND_W-1:0]     out_tuser,  // kind
  output logic                  out_tlast   // last_of_run
);

  logic                  item_valid_r;
  logic [7:0]            byte_r;
  logic                  eod_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic                  out_last_r;
  logic                  slot_free, go;
  res_t                  res;

  assign slot_free = !out_valid_r || out_tready;
  assign go        = item_valid_r && slot_free;
  assign in_tready = !item_valid_r || (go && res.done);

  pbmdec_parse #(
    .DIM_BITS (DIM_BITS)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .byte_i (byte_r),
    .eod_i  (eod_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        item_valid_r <= in_tvalid;
      end
      if (slot_free) begin
        out_valid_r <= go && res.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      eod_r  <= in_tlast;
    end
    if (go && res.emit) begin
      out_data_r <= {res.count, res.height, res.width, res.val, res.addr};
      out_kind_r <= res.kind;
      out_last_r <= res.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_PIXEL |-> out_tlast)
    else $error("status word without last flag");

  a_pixel_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_PIXEL |->
      (out_tdata[31:24] == PIX_BLACK || out_tdata[31:24] == PIX_WHITE))
    else $error("pixel value neither black nor white");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> item_valid_r)
    else $error("accepted word not held");

  a_no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid_r && out_tvalid && out_tready |=> !out_tvalid)
    else $error("result produced without an item");
`endif

endmodule

// ----- tb/pbm_image_stream_decoder_top_test.sv -----
module pbm_image_stream_decoder_top_test import pbmdec_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIX_DIM_MAX = (1 << DIM_BITS_DEF) - 1;
  localparam int unsigned PIX_DIM_SAT = 1 << DIM_BITS_DEF;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          ITEM_TARGET = 460;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  addr;
    logic [VAL_W-1:0]   val;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COUNT_W-1:0] count;
    logic               last;
  } pbm_word_t;

  class pbm_decode_checker;
    phase_t             phase;
    bit                 packed_mode;
    bit [DIM_W-1:0]     width_v;
    bit [DIM_W-1:0]     height_v;
    bit [DIM_W-1:0]     col;
    bit [DIM_W-1:0]     rows_left;
    int unsigned        acc;
    bit                 tok_stop;
    bit [ADDR_W-1:0]    row_base;
    bit [COUNT_W-1:0]   seen;
    bit [KIND_W-1:0]    err_kind;
    pbm_word_t          pending_q[$];
    int                 mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase       = PH_MAGIC0;
      packed_mode = 1'b0;
      width_v     = '0;
      height_v    = '0;
      col         = '0;
      rows_left   = '0;
      acc         = 0;
      tok_stop    = 1'b0;
      row_base    = '0;
      seen        = '0;
      err_kind    = KIND_NONE;
    endfunction

    function void push(bit [KIND_W-1:0] k, bit [ADDR_W-1:0] a, bit [VAL_W-1:0] v);
      pbm_word_t w;
      w.kind   = k;
      w.addr   = a;
      w.val    = v;
      w.width  = width_v;
      w.height = height_v;
      w.count  = seen;
      w.last   = 1'b0;
      pending_q.push_back(w);
    endfunction

    function bit is_space(bit [7:0] b);
      return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function void feed_digit(bit [7:0] b);
      if (!tok_stop && b >= CH_0 && b <= CH_9) begin
        acc = acc * 10 + (b - CH_0);
        if (acc > PIX_DIM_SAT) acc = PIX_DIM_SAT;
      end else begin
        tok_stop = 1'b1;
      end
    endfunction

    function void start_raster();
      if (width_v == 0 || height_v == 0) begin
        phase = PH_DONE;
        return;
      end
      row_base  = ADDR_W'(width_v * (height_v - 1));
      col       = '0;
      rows_left = height_v;
      phase     = PH_DATA;
    endfunction

    // returns 1 when the pixel closes a row
    function bit put_pixel(bit black);
      bit [ADDR_W-1:0] a;
      a    = row_base + col;
      seen = seen + 1;
      push(KIND_PIXEL, a, black ? PIX_BLACK : PIX_WHITE);
      col = col + 1;
      if (col >= width_v) begin
        col       = '0;
        row_base  = row_base - width_v;
        rows_left = rows_left - 1;
        if (rows_left == 0) phase = PH_DONE;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void raise_error(bit [KIND_W-1:0] k);
      err_kind = k;
      phase    = PH_ERROR;
      push(k, '0, '0);
    endfunction

    function void take_byte(bit [7:0] b, bit eod);
      int                start;
      int                i;
      bit [KIND_W-1:0]   k;
      start = pending_q.size();
      if (eod) begin
        case (phase)
          PH_MAGIC0, PH_MAGIC1: k = KIND_NOT_PBM;
          PH_HEIGHT: begin
            if (acc > PIX_DIM_MAX) begin
              k = KIND_BAD_DIM;
            end else begin
              height_v = DIM_W'(acc);
              k = (width_v == 0 || height_v == 0) ? KIND_COMPLETE : KIND_SHORT;
            end
          end
          PH_DONE:  k = KIND_COMPLETE;
          PH_ERROR: k = err_kind;
          default:  k = KIND_SHORT;
        endcase
        push(k, '0, '0);
        pending_q[pending_q.size()-1].last = 1'b1;
        clear();
        return;
      end
      case (phase)
        PH_MAGIC0: begin
          if (b != CH_P) raise_error(KIND_NOT_PBM);
          else phase = PH_MAGIC1;
        end
        PH_MAGIC1: begin
          if (b == CH_1 || b == CH_4) begin
            packed_mode = (b == CH_4);
            phase = PH_SKIP_W;
          end else begin
            raise_error(KIND_NOT_PBM);
          end
        end
        PH_SKIP_W, PH_SKIP_H: begin
          if (!is_space(b)) begin
            acc = 0;
            tok_stop = 1'b0;
            feed_digit(b);
            phase = (phase == PH_SKIP_W) ? PH_WIDTH : PH_HEIGHT;
          end
        end
        PH_WIDTH: begin
          if (is_space(b)) begin
            if (acc > PIX_DIM_MAX) begin
              raise_error(KIND_BAD_DIM);
            end else begin
              width_v = DIM_W'(acc);
              phase = PH_SKIP_H;
            end
          end else begin
            feed_digit(b);
          end
        end
        PH_HEIGHT: begin
          if (is_space(b)) begin
            if (acc > PIX_DIM_MAX) begin
              raise_error(KIND_BAD_DIM);
            end else begin
              height_v = DIM_W'(acc);
              start_raster();
            end
          end else begin
            feed_digit(b);
          end
        end
        PH_DATA: begin
          if (packed_mode) begin
            for (i = 7; i >= 0; i--) begin
              if (put_pixel(b[i])) break;
            end
          end else if (b == CH_0 || b == CH_1) begin
            void'(put_pixel(b == CH_1));
          end
        end
        default: ;
      endcase
      if (pending_q.size() > start) pending_q[pending_q.size()-1].last = 1'b1;
    endfunction

    function void report_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $display("%0t: %s expected %0d got %0d", $time, name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_word(logic [KIND_W-1:0] kind, logic [OUT_DATA_W-1:0] data,
                             logic last);
      pbm_word_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word kind %0d expected none got data %h", $time, kind,
                 data);
        mismatches++;
        return;
      end
      e = pending_q.pop_front();
      report_field("kind", e.kind, kind);
      report_field("pixel_address", e.addr, data[ADDR_W-1:0]);
      report_field("pixel_value", e.val, data[ADDR_W +: VAL_W]);
      report_field("image_width", e.width, data[ADDR_W+VAL_W +: DIM_W]);
      report_field("image_height", e.height, data[ADDR_W+VAL_W+DIM_W +: DIM_W]);
      report_field("pixel_count", e.count, data[ADDR_W+VAL_W+2*DIM_W +: COUNT_W]);
      report_field("last_of_run", e.last, last);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;

  pbm_image_stream_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  pbm_decode_checker chk = new();
  bit [7:0]          file_q[$];
  int                items_sent;
  int                tx_mode;
  int                rx_mode;
  bit                hold_req;
  int                cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int gap_len(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 100 - 15 * mode) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    int g;
    stall_left = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) chk.check_word(out_tuser, out_tdata, out_tlast);
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        g = gap_len(rx_mode);
        if (g > 0) begin
          stall_left = g - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_word(bit [7:0] b, bit eod);
    int g;
    g = gap_len(tx_mode);
    @(negedge clk);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eod;
    do @(posedge clk); while (!in_tready);
    chk.take_byte(b, eod);
    items_sent++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_word(file_q[i], 1'b0);
    send_word($urandom_range(0, 255), 1'b1);
    file_q.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (chk.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic void put_text(string s);
    foreach (s[i]) file_q.push_back(s[i]);
  endfunction

  function automatic void put_ws();
    int r;
    r = $urandom_range(0, 5);
    file_q.push_back(r == 5 ? CH_SP : 8'(CH_TAB + r));
  endfunction

  function automatic bit [7:0] junk_char();
    return 8'($urandom_range(8'h21, 8'h2F));
  endfunction

  function automatic void put_token(int unsigned v);
    if (v == 0 && $urandom_range(0, 2) == 0) begin
      file_q.push_back(junk_char());
      if ($urandom_range(0, 1)) put_text($sformatf("%0d", $urandom_range(1, 99)));
      return;
    end
    if ($urandom_range(0, 9) == 0) file_q.push_back(CH_0);
    put_text($sformatf("%0d", v));
    if ($urandom_range(0, 11) == 0) begin
      file_q.push_back(junk_char());
      if ($urandom_range(0, 1)) put_text($sformatf("%0d", $urandom_range(0, 9999)));
    end
  endfunction

  function automatic int unsigned pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 8);
    if (r < 87) return $urandom_range(9, 24);
    if (r < 91) return 0;
    if (r < 95) return $urandom_range(PIX_DIM_SAT, 99999);
    return PIX_DIM_MAX;
  endfunction

  function automatic void build_random_file();
    int          r;
    int unsigned w;
    int unsigned h;
    int          cut;
    bit          p4;
    bit [7:0]    nb;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      do nb = $urandom_range(0, 255); while (nb == CH_P);
      file_q.push_back(nb);
      repeat ($urandom_range(0, 4)) file_q.push_back($urandom_range(0, 255));
      return;
    end
    file_q.push_back(CH_P);
    if (r < 9) begin
      do nb = $urandom_range(0, 255); while (nb == CH_1 || nb == CH_4);
      file_q.push_back(nb);
      repeat ($urandom_range(0, 4)) file_q.push_back($urandom_range(0, 255));
      return;
    end
    p4 = $urandom_range(0, 1);
    file_q.push_back(p4 ? CH_4 : CH_1);
    w = pick_dim();
    h = pick_dim();
    if (w <= PIX_DIM_MAX && h <= PIX_DIM_MAX && w * h > 400) h = 0;
    repeat ($urandom_range(1, 3)) put_ws();
    put_token(w);
    repeat ($urandom_range(1, 3)) put_ws();
    put_token(h);
    put_ws();
    if (w > 0 && h > 0 && w <= PIX_DIM_MAX && h <= PIX_DIM_MAX) begin
      if (p4) begin
        repeat (h * ((w + 7) / 8)) file_q.push_back($urandom_range(0, 255));
      end else begin
        repeat (w * h) begin
          if ($urandom_range(0, 9) == 0) begin
            do nb = $urandom_range(0, 255); while (nb == CH_0 || nb == CH_1);
            file_q.push_back(nb);
          end
          file_q.push_back($urandom_range(0, 1) ? CH_1 : CH_0);
        end
      end
    end
    if ($urandom_range(0, 99) < 15)
      repeat ($urandom_range(1, 4)) file_q.push_back($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 12) begin
      cut = $urandom_range(0, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endfunction

  initial begin
    int nfile;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    tx_mode    = 0;
    rx_mode    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bad first byte, bad second byte
    put_text("Q");
    send_file();
    put_text("P7");
    send_file();
    // packed: padded rows, whitespace-valued raster byte, trailing byte
    tx_mode = 1;
    rx_mode = 1;
    put_text("P4\t2\n3 ");
    file_q.push_back(CH_SP);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h40);
    file_q.push_back(8'h00);
    send_file();
    // plain: junk after width digits, ignored raster characters
    put_text("P1 3x 1\n1a0 1");
    send_file();
    wait_drained();

    nfile = 0;
    while (items_sent < ITEM_TARGET) begin
      tx_mode = $urandom_range(0, 3);
      rx_mode = $urandom_range(0, 3);
      build_random_file();
      if (nfile == 0 || nfile == 4) begin
        tx_mode = 0;
        hold_req = 1'b1;
      end
      send_file();
      if (nfile % 7 == 6) wait_drained();
      nfile++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (chk.mismatches == 0 && chk.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pbmdec_pkg.sv
hw/rtl/pbmdec_parse.sv
hw/rtl/pbm_image_stream_decoder_top.sv
tb/pbm_image_stream_decoder_top_test.sv
